### src/tslb_pkg.sv
// Shared types and constants for the texture slot binder with LFU replacement.
// Used by the top level and the port checker.
`default_nettype none

package tslb_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int MAX_SLOTS_DEF  = 32;
    localparam int ID_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed port field widths.
    localparam int ACTION_W  = 3;
    localparam int SLOT_W    = 5;
    localparam int TEX_IN_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_BIND    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_COUNT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_VICTIM  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DISABLE = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot_index;
        logic [TEX_IN_W-1:0] texture_id;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   result_slot;
        logic                flag;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RMW,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

### src/tslb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tslb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/texture_slot_lfu_binder_unit.sv
// Top level of the texture slot binder: request decode, scan sequencer, flag bits.
// Depends on tslb_pkg and tslb_ram (texture id and use count per slot).
//
// One request at a time: start is taken while busy is low, and the result appears
// on rsp for exactly one cycle with done high; it cannot be held off. Query,
// disable all, clear all, the unused action code and rejected slot indexes finish
// in the decode state; count use and a bind of the texture already in the slot
// finish in the read-modify-write state. Pick victim and lookup read one slot per
// cycle over the active slots through the single read port of the slot memory,
// issuing then comparing each read, with a closing step if no stop or hit ends it;
// a bind of a new texture sweeps every slot the same way after reading its own slot.
// busy drops in the cycle the result is shown, so the next request may start then.
// The slots_in_use register is written over cfg while busy is low.
`default_nettype none

module texture_slot_lfu_binder_unit #(
    parameter int MAX_SLOTS  = tslb_pkg::MAX_SLOTS_DEF,
    parameter int ID_BITS    = tslb_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = tslb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire tslb_pkg::req_t             req,
    output logic                            done,
    output tslb_pkg::rsp_t                  rsp,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [tslb_pkg::CFG_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > tslb_pkg::CFG_W) ? CNT_W : tslb_pkg::CFG_W;
    localparam int ENT_W = ID_BITS + COUNT_BITS;

    tslb_pkg::state_t state_reg, state_next;
    tslb_pkg::req_t   req_reg, req_next;
    tslb_pkg::rsp_t   rsp_reg, rsp_next;
    logic             done_reg, done_next;

    logic [tslb_pkg::CFG_W-1:0] slots_reg, slots_next;
    logic [MAX_SLOTS-1:0]       enabled_reg, enabled_next;
    logic [MAX_SLOTS-1:0]       mapped_reg, mapped_next;
    logic [MAX_SLOTS-1:0]       written_reg, written_next;

    logic [ID_BITS-1:0]    old_reg, old_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;

    // slot memory ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic                  accept;
    logic [CMP_W-1:0]      cfg_ext;
    logic [CMP_W-1:0]      n_eff;
    logic [CMP_W-1:0]      slot_ext;
    logic                  slot_bad;
    logic [IDX_W-1:0]      slot_idx;
    logic [ID_BITS-1:0]    id_req;
    logic [CMP_W-1:0]      scan_limit;
    logic                  issue_more;
    logic [IDX_W-1:0]      rd_idx;
    logic [ID_BITS-1:0]    ent_tex;
    logic [COUNT_BITS-1:0] ent_cnt;
    logic                  eval;
    logic                  victim_stop;
    logic                  lookup_hit;
    logic                  scan_end;
    logic                  scan_finish;
    logic [CMP_W-1:0]      pend_ext;
    logic [CMP_W-1:0]      best_ext;

    tslb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = start && (state_reg == tslb_pkg::ST_IDLE);
    assign busy      = (state_reg != tslb_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == tslb_pkg::ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Effective slot count: limit to the table, treat zero as one.
    assign cfg_ext = CMP_W'(slots_reg);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_SLOTS))
        begin
            n_eff = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            n_eff = cfg_ext;
        end
    end

    assign slot_ext   = CMP_W'(req_reg.slot_index);
    assign slot_bad   = (slot_ext >= n_eff);
    assign slot_idx   = slot_ext[IDX_W-1:0];
    assign id_req     = ID_BITS'(req_reg.texture_id);
    assign scan_limit = (req_reg.action == tslb_pkg::ACT_BIND) ? CMP_W'(MAX_SLOTS) : n_eff;
    assign issue_more = (CMP_W'(issue_reg) < scan_limit);
    assign pend_ext   = CMP_W'(pend_idx_reg);
    assign best_ext   = CMP_W'(best_reg);

    // Entries never written since reset or clear read as zero.
    assign rd_idx  = (state_reg == tslb_pkg::ST_SCAN) ? pend_idx_reg : slot_idx;
    assign ent_tex = written_reg[rd_idx] ? ram_rdata[COUNT_BITS +: ID_BITS] : '0;
    assign ent_cnt = written_reg[rd_idx] ? ram_rdata[COUNT_BITS-1:0] : '0;

    assign eval        = (state_reg == tslb_pkg::ST_SCAN) && pend_valid_reg;
    assign victim_stop = eval && (req_reg.action == tslb_pkg::ACT_VICTIM)
                         && !enabled_reg[pend_idx_reg];
    assign lookup_hit  = eval && (req_reg.action == tslb_pkg::ACT_LOOKUP)
                         && mapped_reg[pend_idx_reg] && (ent_tex == id_req);
    assign scan_end    = (state_reg == tslb_pkg::ST_SCAN) && !pend_valid_reg && !issue_more;
    assign scan_finish = victim_stop || lookup_hit || scan_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tslb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tslb_pkg::ST_DECODE;
                end
            end
            tslb_pkg::ST_DECODE:
            begin
                unique case (req_reg.action) inside
                    tslb_pkg::ACT_BIND, tslb_pkg::ACT_COUNT:
                    begin
                        state_next = slot_bad ? tslb_pkg::ST_IDLE : tslb_pkg::ST_RMW;
                    end
                    tslb_pkg::ACT_VICTIM, tslb_pkg::ACT_LOOKUP:
                    begin
                        state_next = tslb_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = tslb_pkg::ST_IDLE;
                    end
                endcase
            end
            tslb_pkg::ST_RMW:
            begin
                if ((req_reg.action == tslb_pkg::ACT_BIND) && (ent_tex != id_req))
                begin
                    state_next = tslb_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = tslb_pkg::ST_IDLE;
                end
            end
            tslb_pkg::ST_SCAN:
            begin
                if (scan_finish)
                begin
                    state_next = tslb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tslb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        slots_next      = slots_reg;
        enabled_next    = enabled_reg;
        mapped_next     = mapped_reg;
        written_next    = written_reg;
        old_next        = old_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_next       = best_reg;
        best_cnt_next   = best_cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_idx;
        ram_wdata       = {id_req, {COUNT_BITS{1'b0}}};
        ram_raddr       = slot_idx;

        unique case (state_reg)
            tslb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                end
                if (cfg_valid)
                begin
                    slots_next = cfg_data;
                end
            end
            tslb_pkg::ST_DECODE:
            begin
                rsp_next = '0;
                unique case (req_reg.action) inside
                    tslb_pkg::ACT_BIND, tslb_pkg::ACT_COUNT:
                    begin
                        // read of the addressed slot is issued by ram_raddr
                        if (slot_bad)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = tslb_pkg::STATUS_BAD_SLOT;
                        end
                    end
                    tslb_pkg::ACT_QUERY:
                    begin
                        done_next = 1'b1;
                        if (slot_bad)
                        begin
                            rsp_next.status = tslb_pkg::STATUS_BAD_SLOT;
                        end
                        else
                        begin
                            rsp_next.flag = enabled_reg[slot_idx];
                        end
                    end
                    tslb_pkg::ACT_VICTIM, tslb_pkg::ACT_LOOKUP:
                    begin
                        issue_next    = '0;
                        best_next     = '0;
                        best_cnt_next = '1;
                    end
                    tslb_pkg::ACT_DISABLE:
                    begin
                        done_next    = 1'b1;
                        enabled_next = '0;
                    end
                    tslb_pkg::ACT_CLEAR:
                    begin
                        done_next    = 1'b1;
                        enabled_next = '0;
                        mapped_next  = '0;
                        written_next = '0;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            tslb_pkg::ST_RMW:
            begin
                rsp_next = '0;
                if (req_reg.action == tslb_pkg::ACT_BIND)
                begin
                    if (ent_tex == id_req)
                    begin
                        done_next              = 1'b1;
                        enabled_next[slot_idx] = 1'b1;
                    end
                    else
                    begin
                        // sweep all slots and unmap the old and new ids
                        old_next   = ent_tex;
                        issue_next = '0;
                    end
                end
                else
                begin
                    done_next              = 1'b1;
                    ram_we                 = 1'b1;
                    ram_wdata              = {ent_tex, ent_cnt + COUNT_BITS'(1)};
                    written_next[slot_idx] = 1'b1;
                end
            end
            tslb_pkg::ST_SCAN:
            begin
                rsp_next  = '0;
                ram_raddr = issue_reg[IDX_W-1:0];
                if (issue_more && !scan_finish)
                begin
                    issue_next      = issue_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[IDX_W-1:0];
                end

                if (eval)
                begin
                    case (req_reg.action)
                        tslb_pkg::ACT_BIND:
                        begin
                            if ((ent_tex == old_reg) || (ent_tex == id_req))
                            begin
                                mapped_next[pend_idx_reg] = 1'b0;
                            end
                        end
                        tslb_pkg::ACT_VICTIM:
                        begin
                            if (enabled_reg[pend_idx_reg] && (ent_cnt < best_cnt_reg))
                            begin
                                best_next     = pend_idx_reg;
                                best_cnt_next = ent_cnt;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (victim_stop)
                begin
                    done_next            = 1'b1;
                    rsp_next.result_slot = pend_ext[tslb_pkg::SLOT_W-1:0];
                end
                else if (lookup_hit)
                begin
                    done_next            = 1'b1;
                    rsp_next.result_slot = pend_ext[tslb_pkg::SLOT_W-1:0];
                    rsp_next.flag        = 1'b1;
                end
                else if (scan_end)
                begin
                    done_next = 1'b1;
                    case (req_reg.action)
                        tslb_pkg::ACT_BIND:
                        begin
                            ram_we                 = 1'b1;
                            written_next[slot_idx] = 1'b1;
                            mapped_next[slot_idx]  = 1'b1;
                            enabled_next[slot_idx] = 1'b1;
                        end
                        tslb_pkg::ACT_VICTIM:
                        begin
                            rsp_next.result_slot = best_ext[tslb_pkg::SLOT_W-1:0];
                        end
                        default:
                        begin
                            rsp_next.status = tslb_pkg::STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tslb_pkg::ST_IDLE;
            done_reg       <= 1'b0;
            slots_reg      <= tslb_pkg::CFG_RESET;
            enabled_reg    <= '0;
            mapped_reg     <= '0;
            written_reg    <= '0;
            pend_valid_reg <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            slots_reg      <= slots_next;
            enabled_reg    <= enabled_next;
            mapped_reg     <= mapped_next;
            written_reg    <= written_next;
            pend_valid_reg <= pend_valid_next;
            issue_reg      <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        old_reg      <= old_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
    end

endmodule

`default_nettype wire

### src/tslb_checker.sv
// Port-level checks for texture_slot_lfu_binder_unit, bound to every instance.
// Depends on tslb_pkg.
`default_nettype none

module tslb_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire tslb_pkg::rsp_t rsp
);

    // a result always closes a request, so the block is free while it is shown
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted request holds the block and never answers in the next cycle
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not occupy the block");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_fail_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != tslb_pkg::STATUS_OK)) |-> (!rsp.flag && (rsp.result_slot == '0)))
        else $error("failed request carries a flag or slot");

endmodule

bind texture_slot_lfu_binder_unit tslb_checker u_tslb_checker (.*);

`default_nettype wire
